### rtl/postfix_stack_evaluator_unit_defines.svh
// assertion macros for the top-level rtl file of the postfix stack evaluator
`ifndef POSTFIX_STACK_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// the property must hold at every clock edge outside reset
`define PSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// the expression must never be true outside reset
`define PSE_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define PSE_ASSERT(label, prop, msg)

`define PSE_ASSERT_NEVER(label, expr, msg)

`endif

`endif

### rtl/pse_pkg.sv
// types and constants of the postfix stack evaluator
package pse_pkg;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  localparam int ALU_STEPS = 32;
  localparam int ALU_CNT_W = $clog2(ALU_STEPS);

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] operand_value;
    logic               last_token;
  } pse_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } pse_out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PREV,
    CELL_NEXT
  } cell_op_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CALC,
    FSM_EMIT
  } fsm_state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } alu_rsp_t;

endpackage

### rtl/pse_cell.sv
// one stack cell: holds a value, or takes it from the neighbour above or below
module pse_cell (
  input  logic              clk,
  input  pse_pkg::cell_op_t op,
  input  logic [31:0]       prev_value,
  input  logic [31:0]       next_value,
  output logic [31:0]       value
);
  import pse_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      CELL_PREV: value <= prev_value;
      CELL_NEXT: value <= next_value;
      default:   value <= value;
    endcase
  end

endmodule

### rtl/pse_alu.sv
// iterative shift-add multiplier and restoring divider, one bit per cycle
module pse_alu (
  input  logic              clk,
  input  logic              rst,
  input  pse_pkg::alu_req_t req,
  input  logic [31:0]       lhs,
  input  logic [31:0]       rhs,
  output pse_pkg::alu_rsp_t rsp
);
  import pse_pkg::*;

  logic                 running;
  logic                 fin;
  logic                 is_div;
  logic                 neg;
  logic [ALU_CNT_W-1:0] count;
  logic [31:0]          acc;
  logic [31:0]          opa;
  logic [31:0]          opb;
  logic [32:0]          trial;
  logic [31:0]          lhs_mag;
  logic [31:0]          rhs_mag;

  assign lhs_mag = lhs[31] ? (~lhs + 32'd1) : lhs;
  assign rhs_mag = rhs[31] ? (~rhs + 32'd1) : rhs;

  // remainder stays below the divisor, so the shifted trial fits 33 bits
  assign trial = {acc, opa[31]} - {1'b0, opb};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      count   <= '0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + ALU_CNT_W'(1);
        if (count == ALU_CNT_W'(ALU_STEPS - 1)) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.is_div;
      acc    <= '0;
      neg    <= lhs[31] ^ rhs[31];
      if (req.is_div) begin
        opa <= lhs_mag;
        opb <= rhs_mag;
      end else begin
        opa <= lhs;
        opb <= rhs;
      end
    end else if (running) begin
      if (is_div) begin
        if (!trial[32]) begin
          acc <= trial[31:0];
          opa <= {opa[30:0], 1'b1};
        end else begin
          acc <= {acc[30:0], opa[31]};
          opa <= {opa[30:0], 1'b0};
        end
      end else begin
        if (opb[0]) begin
          acc <= acc + opa;
        end
        opa <= {opa[30:0], 1'b0};
        opb <= {1'b0, opb[31:1]};
      end
    end
  end

  assign rsp.done   = fin;
  assign rsp.result = is_div ? (neg ? (~opa + 32'd1) : opa) : acc;

endmodule

### rtl/postfix_stack_evaluator_unit.sv
// top level of the postfix stack evaluator: control, cell chain and output register
//
// in_data carries one postfix token per transaction: push an operand, or
// add, subtract, multiply or divide the two values at the top of the stack.
// out_data carries one transaction per expression, after the token that has
// last_token set: the top of the stack and a status (ok, underflow,
// overflow, divide by zero, empty). Stack and error are then cleared.
// Push, add, subtract and unused opcodes finish in the idle state; multiply and
// divide wait in the calc state for the bit-per-cycle loop of the shared alu. A last
// token then passes the emit state to move the outcome into the output register.
// The stack is a chain of STACK_DEPTH cells shifting in lock step, top in
// cell zero, so push and pop need no addressing.
// in_ready is high whenever no token is in progress; a result waiting in the
// output register does not stop later tokens, and only a further last token
// waits for out_ready. Reset empties the stack, clears the error and drops
// out_valid; cell contents are not cleared.
`include "postfix_stack_evaluator_unit_defines.svh"

module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pse_pkg::pse_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pse_pkg::pse_out_t out_data
);
  import pse_pkg::*;

  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

  fsm_state_t         state;
  fsm_state_t         state_next;
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_next;
  logic [2:0]         err;
  logic [2:0]         err_next;
  logic               pend_last;
  logic               pend_last_next;
  logic               emit;
  cell_op_t           op_top;
  cell_op_t           op_rest;
  logic [31:0]        load_value;
  logic [31:0]        cell_value [STACK_DEPTH];
  logic [31:0]        rhs_v;
  logic [31:0]        lhs_v;
  logic               full;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  pse_out_t           out_next;

  assign rhs_v    = cell_value[0];
  assign lhs_v    = cell_value[1];
  assign full     = (depth == DEPTH_W'(STACK_DEPTH));
  assign in_ready = !rst && (state == FSM_IDLE);

  // stack cells: cell zero is the top, prev is the cell nearer the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [31:0] prev_v;
    logic [31:0] next_v;
    if (i == 0) begin : g_top
      assign prev_v = load_value;
    end else begin : g_mid
      assign prev_v = cell_value[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign next_v = '0;
    end else begin : g_inner
      assign next_v = cell_value[i+1];
    end
    pse_cell u_cell (
      .clk        (clk),
      .op         ((i == 0) ? op_top : op_rest),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cell_value[i])
    );
  end

  pse_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .lhs (lhs_v),
    .rhs (rhs_v),
    .rsp (alu_rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (in_valid) begin
          if (alu_req.start) begin
            state_next = FSM_CALC;
          end else if (in_data.last_token) begin
            state_next = FSM_EMIT;
          end
        end
      end
      FSM_CALC: begin
        if (alu_rsp.done) begin
          state_next = pend_last ? FSM_EMIT : FSM_IDLE;
        end
      end
      FSM_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    op_top         = CELL_HOLD;
    op_rest        = CELL_HOLD;
    load_value     = in_data.operand_value;
    depth_next     = depth;
    err_next       = err;
    pend_last_next = pend_last;
    alu_req        = '0;
    emit           = 1'b0;
    case (state)
      FSM_IDLE: begin
        if (in_valid) begin
          pend_last_next = in_data.last_token;
          if (err == ST_OK) begin
            if (in_data.opcode == OP_PUSH) begin
              if (full) begin
                err_next = ST_OVERFLOW;
              end else begin
                op_top     = CELL_PREV;
                op_rest    = CELL_PREV;
                depth_next = depth + DEPTH_W'(1);
              end
            end else if (in_data.opcode inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) begin
              if (depth < DEPTH_W'(2)) begin
                err_next = ST_UNDERFLOW;
              end else if (in_data.opcode == OP_DIV && rhs_v == 32'd0) begin
                err_next = ST_DIVZERO;
              end else if (in_data.opcode inside {OP_MUL, OP_DIV}) begin
                alu_req.start  = 1'b1;
                alu_req.is_div = (in_data.opcode == OP_DIV);
              end else begin
                op_top     = CELL_PREV;
                op_rest    = CELL_NEXT;
                load_value = (in_data.opcode == OP_ADD) ? (lhs_v + rhs_v) : (lhs_v - rhs_v);
                depth_next = depth - DEPTH_W'(1);
              end
            end
          end
        end
      end
      FSM_CALC: begin
        if (alu_rsp.done) begin
          op_top     = CELL_PREV;
          op_rest    = CELL_NEXT;
          load_value = alu_rsp.result;
          depth_next = depth - DEPTH_W'(1);
        end
      end
      FSM_EMIT: begin
        if (!out_valid || out_ready) begin
          emit       = 1'b1;
          depth_next = '0;
          err_next   = ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_next.result_value = '0;
    if (err != ST_OK) begin
      out_next.status = err;
    end else if (depth == '0) begin
      out_next.status = ST_EMPTY;
    end else begin
      out_next.status       = ST_OK;
      out_next.result_value = rhs_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      depth     <= '0;
      err       <= ST_OK;
      pend_last <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      depth     <= depth_next;
      err       <= err_next;
      pend_last <= pend_last_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= out_next;
    end
  end

  `PSE_ASSERT_NEVER(a_depth_bound, depth > DEPTH_W'(STACK_DEPTH), "stack depth beyond capacity")
  `PSE_ASSERT(a_done_in_calc, alu_rsp.done |-> state == FSM_CALC, "alu finished outside calc")
  `PSE_ASSERT(a_emit_loads, emit |=> out_valid, "emitted result not presented")
  `PSE_ASSERT(a_err_holds, (err != ST_OK && state != FSM_EMIT) |=> $stable(err), "latched error changed")
  `PSE_ASSERT(a_err_zero, (out_valid && out_data.status != ST_OK) |-> out_data.result_value == 0, "non-zero value with error")

endmodule
